>>> design/rirb_pkg.sv
// ----------------------------------------------------------------------------
// Record/replay buffer package
// Shared constants, command and mode codes, and the structs that the control
// stage passes to the frame store and to the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rirb_pkg;

    // Number of frames the store holds and the stored width of one pad word.
    localparam int FRAME_DEPTH = 4096;
    localparam int PAD_WIDTH   = 64;

    // Derived widths.
    localparam int ADDR_W     = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int COUNT_W    = $clog2(FRAME_DEPTH + 1);
    localparam int PAD_BUS_W  = 4 * PAD_WIDTH;
    localparam int PORT_PAD_W = 64;
    localparam int BUTTON_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Start, X and B buttons of pad 0.
    localparam logic [BUTTON_W-1:0] COMBO_MASK_RESET = 16'h1600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_ENABLE = 1'b0,
        CFG_COMBO_MASK  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_START_REC  = 3'd1,
        CMD_STOP_REC   = 3'd2,
        CMD_START_PLAY = 3'd3,
        CMD_STOP_PLAY  = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_MARK_RESET = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } mode_t;

    // Frame store access requested by the control stage.
    typedef struct packed {
        logic              pad_we;
        logic              pad_re;
        logic [ADDR_W-1:0] pad_addr;
        logic              flag_we;
        logic              flag_re;
        logic [ADDR_W-1:0] flag_addr;
        logic              flag_wdata;
    } rirb_mem_t;

    // Status of one request after the control stage, aligned with the read data.
    typedef struct packed {
        logic               driven;
        logic               wrap;
        logic               combo_clear;
        logic               full;
        mode_t              mode;
        logic [COUNT_W-1:0] frame_total;
        logic [ADDR_W-1:0]  play_position;
    } rirb_info_t;

endpackage

`default_nettype wire

>>> design/rirb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rirb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                            wdata,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/rirb_ctrl.sv
// ----------------------------------------------------------------------------
// Record/replay control stage
// Decodes each request, updates mode, frame count, play position and the
// pending reset mark, and issues the frame store access for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rirb_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               accept,
    input  wire logic [2:0]                         cmd,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    in_pad0,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    in_pad1,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    in_pad2,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    in_pad3,
    input  wire logic                               live_reset,
    input  wire logic                               loop_enable,
    output rirb_pkg::rirb_mem_t                     mem,
    output logic      [rirb_pkg::PAD_BUS_W-1:0]     pad_wdata,
    output rirb_pkg::rirb_info_t                    info
);
    import rirb_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0]  position_reg, position_next;
    logic               pending_reg, pending_next;
    rirb_info_t         info_reg, info_next;

    logic [ADDR_W-1:0]  play_idx;
    logic [COUNT_W-1:0] play_inc;
    logic [COUNT_W-1:0] count_m1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            count_reg    <= '0;
            position_reg <= '0;
            pending_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            position_reg <= position_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            info_reg <= info_next;
        end
    end

    assign pad_wdata = {in_pad3[PAD_WIDTH-1:0], in_pad2[PAD_WIDTH-1:0],
                        in_pad1[PAD_WIDTH-1:0], in_pad0[PAD_WIDTH-1:0]};

    // Position past the end can only follow a shrunk store; restart at frame zero.
    assign play_idx = (COUNT_W'(position_reg) >= count_reg) ? '0 : position_reg;
    assign play_inc = COUNT_W'(play_idx) + COUNT_W'(1);
    assign count_m1 = count_reg - COUNT_W'(1);

    always_comb begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        position_next = position_reg;
        pending_next  = pending_reg;

        mem            = '0;
        mem.pad_addr   = count_reg[ADDR_W-1:0];
        mem.flag_addr  = count_reg[ADDR_W-1:0];
        mem.flag_wdata = live_reset | pending_reg;

        info_next             = '0;
        info_next.mode        = mode_reg;

        case (cmd_t'(cmd))
            CMD_TICK: begin
                if (mode_reg == MODE_REC) begin
                    if (count_reg < COUNT_W'(FRAME_DEPTH)) begin
                        mem.pad_we   = accept;
                        mem.flag_we  = accept;
                        pending_next = 1'b0;
                        count_next   = count_reg + COUNT_W'(1);
                    end else begin
                        info_next.full = 1'b1;
                    end
                end else if (mode_reg == MODE_PLAY && count_reg != '0) begin
                    mem.pad_re       = accept;
                    mem.flag_re      = accept;
                    mem.pad_addr     = play_idx;
                    mem.flag_addr    = play_idx;
                    info_next.driven = 1'b1;
                    if (play_inc >= count_reg) begin
                        info_next.wrap = 1'b1;
                        position_next  = '0;
                        if (!loop_enable) begin
                            mode_next = MODE_IDLE;
                        end
                    end else begin
                        position_next = play_inc[ADDR_W-1:0];
                    end
                end
            end
            CMD_START_REC: begin
                count_next            = '0;
                position_next         = '0;
                pending_next          = 1'b0;
                info_next.combo_clear = 1'b1;
                mode_next             = MODE_REC;
            end
            CMD_STOP_REC: begin
                if (mode_reg == MODE_REC) begin
                    mode_next = MODE_IDLE;
                end
            end
            CMD_START_PLAY: begin
                position_next = '0;
                if (count_reg == '0) begin
                    mode_next = MODE_IDLE;
                end else begin
                    pending_next          = 1'b0;
                    info_next.combo_clear = 1'b1;
                    mode_next             = MODE_PLAY;
                end
            end
            CMD_STOP_PLAY: begin
                if (mode_reg == MODE_PLAY) begin
                    mode_next = MODE_IDLE;
                end
                position_next         = '0;
                pending_next          = 1'b0;
                info_next.combo_clear = 1'b1;
            end
            CMD_CLEAR: begin
                count_next            = '0;
                position_next         = '0;
                pending_next          = 1'b0;
                info_next.combo_clear = 1'b1;
                mode_next             = MODE_IDLE;
            end
            CMD_MARK_RESET: begin
                if (mode_reg == MODE_REC) begin
                    if (count_reg == '0) begin
                        pending_next = 1'b1;
                    end else begin
                        // Flag the most recent frame.
                        mem.flag_we    = accept;
                        mem.flag_addr  = count_m1[ADDR_W-1:0];
                        mem.flag_wdata = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        info_next.mode          = mode_next;
        info_next.frame_total   = count_next;
        info_next.play_position = position_next;
    end

    assign info = info_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(FRAME_DEPTH))
        else $error("frame count exceeds the store depth");

    a_play_needs_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_PLAY |-> count_reg != '0)
        else $error("playing with an empty store");

    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg == '0 || COUNT_W'(position_reg) < count_reg)
        else $error("play position beyond the recorded frames");
`endif

endmodule

`default_nettype wire

>>> design/rirb_out.sv
// ----------------------------------------------------------------------------
// Record/replay output stage
// Combines the frame read back from the store with the status of its request,
// detects the rising edge of the reset combo and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rirb_out (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               a_valid,
    input  wire rirb_pkg::rirb_info_t               info,
    input  wire logic [rirb_pkg::PAD_BUS_W-1:0]     pad_rdata,
    input  wire logic                               flag_rdata,
    input  wire logic [rirb_pkg::BUTTON_W-1:0]      combo_mask,
    input  wire logic                               m_ready,
    output logic                                    a_take,
    output logic                                    m_valid,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad0,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad1,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad2,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad3,
    output logic                                    m_pads_driven,
    output logic                                    m_replay_reset,
    output logic      [1:0]                         m_mode,
    output logic      [rirb_pkg::COUNT_W-1:0]       m_frame_total,
    output logic      [rirb_pkg::ADDR_W-1:0]        m_play_position,
    output logic                                    m_store_full
);
    import rirb_pkg::*;

    logic                  m_valid_reg, m_valid_next;
    logic                  combo_held_reg, combo_held_next;
    logic [PORT_PAD_W-1:0] pad0_reg, pad1_reg, pad2_reg, pad3_reg;
    logic                  driven_reg, rreset_reg, full_reg;
    logic [1:0]            mode_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [ADDR_W-1:0]     position_reg;

    logic                  held;
    logic                  rreset_next;

    assign a_take = a_valid && (!m_valid_reg || m_ready);

    assign held        = (pad_rdata[BUTTON_W-1:0] & combo_mask) == combo_mask;
    assign rreset_next = info.driven && (flag_rdata || (held && !combo_held_reg));

    always_comb begin
        combo_held_next = combo_held_reg;
        if (info.driven) begin
            combo_held_next = held && !info.wrap;
        end else if (info.combo_clear) begin
            combo_held_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (a_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            combo_held_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (a_take) begin
                combo_held_reg <= combo_held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_take) begin
            pad0_reg     <= info.driven ? PORT_PAD_W'(pad_rdata[0*PAD_WIDTH +: PAD_WIDTH]) : '0;
            pad1_reg     <= info.driven ? PORT_PAD_W'(pad_rdata[1*PAD_WIDTH +: PAD_WIDTH]) : '0;
            pad2_reg     <= info.driven ? PORT_PAD_W'(pad_rdata[2*PAD_WIDTH +: PAD_WIDTH]) : '0;
            pad3_reg     <= info.driven ? PORT_PAD_W'(pad_rdata[3*PAD_WIDTH +: PAD_WIDTH]) : '0;
            driven_reg   <= info.driven;
            rreset_reg   <= rreset_next;
            full_reg     <= info.full;
            mode_reg     <= info.mode;
            total_reg    <= info.frame_total;
            position_reg <= info.play_position;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_pad0      = pad0_reg;
    assign m_out_pad1      = pad1_reg;
    assign m_out_pad2      = pad2_reg;
    assign m_out_pad3      = pad3_reg;
    assign m_pads_driven   = driven_reg;
    assign m_replay_reset  = rreset_reg;
    assign m_mode          = mode_reg;
    assign m_frame_total   = total_reg;
    assign m_play_position = position_reg;
    assign m_store_full    = full_reg;

`ifndef ASSERT_OFF
    a_reset_needs_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && rreset_reg |-> driven_reg)
        else $error("replay reset raised without a replayed frame");

    a_idle_pads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !driven_reg |->
            pad0_reg == '0 && pad1_reg == '0 && pad2_reg == '0 && pad3_reg == '0)
        else $error("pad words present on a request that replayed nothing");

    a_full_only_recording: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && full_reg |-> mode_reg == MODE_REC && !driven_reg)
        else $error("store full reported outside recording");
`endif

endmodule

`default_nettype wire

>>> design/input_record_replay_buffer_top.sv
// ----------------------------------------------------------------------------
// Input record/replay buffer
// Records per-tick frames of four pad words and a reset flag, and plays them
// back with optional looping and combo-triggered replay reset.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel carries one command and, for a tick, the live
// pad words and reset flag. Every request produces exactly one result on the
// m_ channel, in order, reporting the replayed pads (when playing), the
// replay reset, the mode after the request, the frame count, the next play
// position and whether a recording tick was dropped because the store is full.
// The accepting edge loads the control stage, where the frame store is written
// or read. The output stage, where the read data meets the combo detector, is
// loaded as soon as its register is free, and the result is held there until
// the receiver takes it.
// Throughput is one request per cycle while the receiver keeps m_ready high;
// the single-port frame store takes at most one access per request.
// When the receiver stalls, the output register holds its result and the
// control stage keeps its request, with the store read data held, so
// s_ready drops only once both stages are occupied.
// Synchronous reset returns the block to idle with an empty store, clears
// loop_enable and loads the default combo mask. The frame store itself is not
// cleared, as no frame is ever read before it has been recorded.
// Make cfg_we configuration writes with no request in flight; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module input_record_replay_buffer_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [rirb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rirb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [2:0]                         s_cmd,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    s_in_pad0,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    s_in_pad1,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    s_in_pad2,
    input  wire logic [rirb_pkg::PORT_PAD_W-1:0]    s_in_pad3,
    input  wire logic                               s_live_reset,
    // Result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad0,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad1,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad2,
    output logic      [rirb_pkg::PORT_PAD_W-1:0]    m_out_pad3,
    output logic                                    m_pads_driven,
    output logic                                    m_replay_reset,
    output logic      [1:0]                         m_mode,
    output logic      [rirb_pkg::COUNT_W-1:0]       m_frame_total,
    output logic      [rirb_pkg::ADDR_W-1:0]        m_play_position,
    output logic                                    m_store_full
);
    import rirb_pkg::*;

    // Configuration registers.
    logic                loop_enable_reg;
    logic [BUTTON_W-1:0] combo_mask_reg;

    // The control stage register is occupied while a request waits for the
    // output register.
    logic                a_valid_reg, a_valid_next;
    logic                accept;
    logic                a_take;

    rirb_mem_t           mem;
    rirb_info_t          info;
    logic [PAD_BUS_W-1:0] pad_wdata;
    logic [PAD_BUS_W-1:0] pad_rdata;
    logic                flag_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_enable_reg <= 1'b0;
            combo_mask_reg  <= COMBO_MASK_RESET;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOOP_ENABLE: loop_enable_reg <= cfg_wdata[0];
                CFG_COMBO_MASK:  combo_mask_reg  <= cfg_wdata[BUTTON_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A new request may enter as the one in the control stage moves on.
    assign s_ready = !a_valid_reg || a_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (a_take) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    rirb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_cmd),
        .in_pad0     (s_in_pad0),
        .in_pad1     (s_in_pad1),
        .in_pad2     (s_in_pad2),
        .in_pad3     (s_in_pad3),
        .live_reset  (s_live_reset),
        .loop_enable (loop_enable_reg),
        .mem         (mem),
        .pad_wdata   (pad_wdata),
        .info        (info)
    );

    // Pad words of all four pads share one wide store; the reset flags have
    // their own so that a reset mark can update a flag alone.
    rirb_ram #(
        .WIDTH (PAD_BUS_W),
        .DEPTH (FRAME_DEPTH)
    ) u_pad_ram (
        .aclk  (aclk),
        .we    (mem.pad_we),
        .re    (mem.pad_re),
        .addr  (mem.pad_addr),
        .wdata (pad_wdata),
        .rdata (pad_rdata)
    );

    rirb_ram #(
        .WIDTH (1),
        .DEPTH (FRAME_DEPTH)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (mem.flag_we),
        .re    (mem.flag_re),
        .addr  (mem.flag_addr),
        .wdata (mem.flag_wdata),
        .rdata (flag_rdata)
    );

    rirb_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .a_valid         (a_valid_reg),
        .info            (info),
        .pad_rdata       (pad_rdata),
        .flag_rdata      (flag_rdata),
        .combo_mask      (combo_mask_reg),
        .m_ready         (m_ready),
        .a_take          (a_take),
        .m_valid         (m_valid),
        .m_out_pad0      (m_out_pad0),
        .m_out_pad1      (m_out_pad1),
        .m_out_pad2      (m_out_pad2),
        .m_out_pad3      (m_out_pad3),
        .m_pads_driven   (m_pads_driven),
        .m_replay_reset  (m_replay_reset),
        .m_mode          (m_mode),
        .m_frame_total   (m_frame_total),
        .m_play_position (m_play_position),
        .m_store_full    (m_store_full)
    );

endmodule

`default_nettype wire
